### rtl/tgce_pkg.sv
// ----------------------------------------------------------------------------
// tgce_pkg
// Shared types, constants and helpers of the text glyph color expander.
// ----------------------------------------------------------------------------
package tgce_pkg;

    // Fixed field widths
    localparam int CODE_IN_W   = 8;
    localparam int CELL_W      = 16;
    localparam int GROW_W      = 5;
    localparam int ADDR_OUT_W  = 20;
    localparam int DATA_OUT_W  = 32;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    // Glyph geometry and result limit
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_SHIFT  = $clog2(GLYPH_WIDTH);
    localparam int RESULT_LIMIT = 64;

    // Row base arithmetic is kept modulo 2^22 (20 address bits plus byte offset)
    localparam int BASE_W = ADDR_OUT_W + 2;

    // Divider steps, one quotient bit per step
    localparam int DIV_STEPS = CELL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Row and word counters
    localparam int ROW_W   = 5;
    localparam int ROWS_W  = 6;
    localparam int WORD_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_PER_LINE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FONT_HEIGHT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_DEPTH    = 2'd3;

    // Opcodes
    localparam logic OP_GLYPH_WRITE = 1'b0;
    localparam logic OP_DRAW        = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic                glyph_write;
        logic                load;
        logic                div_step;
        logic                mul_line;
        logic                mul_base;
        logic                row_read;
        logic                emit;
        logic                emit_last;
        logic                row_adv;
        logic [ROW_W-1:0]    row;
        logic [WORD_W-1:0]   word;
    } tgce_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic                slot_free;
        logic                deep;
        logic [ROWS_W-1:0]   rows;
    } tgce_sts_t;

    // Expand one word's share of a glyph row into an output word; leftmost pixel to lowest byte
    function automatic logic [DATA_OUT_W-1:0] tgce_expand(
        input logic [7:0]        bits,
        input logic [7:0]        attr,
        input logic [WORD_W-1:0] word,
        input logic              deep
    );
        logic [DATA_OUT_W-1:0] w;
        logic [2:0]            px;
        w  = '0;
        px = '0;
        for (int k = 0; k < 4; k++)
        begin
            if (deep)
            begin
                if (k < 2)
                begin
                    px = 3'(32'(word) * 2 + k);
                    if (bits[3'd7 - px])
                        w[16*k +: 8] = attr;
                end
            end
            else
            begin
                px = 3'(32'(word) * 4 + k);
                if (bits[3'd7 - px])
                    w[8*k +: 8] = attr;
            end
        end
        return w;
    endfunction

endpackage

### rtl/tgce_if.sv
// ----------------------------------------------------------------------------
// tgce_in_if / tgce_out_if
// Valid/ready channels for draw and glyph requests and for framebuffer words.
// ----------------------------------------------------------------------------
interface tgce_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_code;
    logic [7:0] attribute;
    logic [15:0] cell_index;
    logic [4:0] glyph_row;
    logic [7:0] glyph_bits;
    logic       string_end;

    modport source (output valid, opcode, char_code, attribute, cell_index,
                    glyph_row, glyph_bits, string_end, input ready);
    modport sink   (input valid, opcode, char_code, attribute, cell_index,
                    glyph_row, glyph_bits, string_end, output ready);
endinterface

interface tgce_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] word_address;
    logic [31:0] word_data;
    logic        cell_done;
    logic        run_done;

    modport source (output valid, word_address, word_data, cell_done, run_done,
                    input ready);
    modport sink   (input valid, word_address, word_data, cell_done, run_done,
                    output ready);
endinterface

### rtl/tgce_datapath.sv
// ----------------------------------------------------------------------------
// tgce_datapath
// Configuration, glyph store, cell divider, address arithmetic and the
// output word register.
// ----------------------------------------------------------------------------
module tgce_datapath
    import tgce_pkg::*;
#(
    parameter int GLYPH_COUNT   = 256,
    parameter int MAX_FONT_ROWS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  tgce_cmd_t              cmd,
    output tgce_sts_t              sts,
    input  logic [7:0]             in_char_code,
    input  logic [7:0]             in_attribute,
    input  logic [CELL_W-1:0]      in_cell_index,
    input  logic [GROW_W-1:0]      in_glyph_row,
    input  logic [7:0]             in_glyph_bits,
    input  logic                   in_string_end,
    tgce_out_if.source             out_ch
);

    localparam int DEPTH  = GLYPH_COUNT * MAX_FONT_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CODE_W = $clog2(GLYPH_COUNT);
    localparam int RECIP  = (65536 + GLYPH_COUNT - 1) / GLYPH_COUNT;

    // Configuration registers
    logic [7:0]  cpl_reg;
    logic [10:0] swp_reg;
    logic [5:0]  fh_reg;
    logic        deep_reg;

    // Item registers
    logic [CODE_W-1:0]     code_reg;
    logic [7:0]            attr_reg;
    logic                  send_reg;
    logic [CELL_W-1:0]     quo_reg;
    logic [7:0]            rem_reg;
    logic [BASE_W-1:0]     line_reg;
    logic [BASE_W-1:0]     row_base_reg;
    logic [7:0]            glyph_q_reg;

    // Output register
    logic                  out_valid_reg;
    logic [ADDR_OUT_W-1:0] out_addr_reg;
    logic [DATA_OUT_W-1:0] out_data_reg;
    logic                  out_cell_reg;
    logic                  out_run_reg;

    logic [7:0] glyph_mem [DEPTH];

    logic [7:0]            cpl_eff;
    logic [5:0]            h_eff;
    logic [ROWS_W-1:0]     rows;
    logic [20:0]           code_prod;
    logic [4:0]            code_quo;
    logic [7:0]            code_rem;
    logic [CODE_W-1:0]     code_mod;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  row_in_range;
    logic [8:0]            div_part;
    logic [8:0]            div_diff;
    logic                  div_take;
    logic [ADDR_OUT_W-1:0] word_base;

    // Effective columns, height and emitted rows
    assign cpl_eff = (cpl_reg == 8'd0) ? 8'd1 : cpl_reg;
    assign h_eff   = (7'(fh_reg) < 7'(MAX_FONT_ROWS)) ? fh_reg : 6'(MAX_FONT_ROWS);

    always_comb
    begin
        rows = ROWS_W'(h_eff);
        if (deep_reg && (8'(h_eff) * 8'd4 > 8'(RESULT_LIMIT)))
            rows = ROWS_W'(RESULT_LIMIT / 4);
        else if (!deep_reg && (8'(h_eff) * 8'd2 > 8'(RESULT_LIMIT)))
            rows = ROWS_W'(RESULT_LIMIT / 2);
    end

    assign sts.slot_free = !out_valid_reg || out_ch.ready;
    assign sts.deep      = deep_reg;
    assign sts.rows      = rows;

    // Character code modulo glyph count by reciprocal multiply
    assign code_prod = 21'(in_char_code) * 21'(RECIP);
    assign code_quo  = code_prod[20:16];
    assign code_rem  = in_char_code - 8'(32'(code_quo) * GLYPH_COUNT);
    assign code_mod  = code_rem[CODE_W-1:0];

    assign row_in_range = 7'(in_glyph_row) < 7'(MAX_FONT_ROWS);
    assign wr_addr = ADDR_W'(32'(code_mod) * MAX_FONT_ROWS + 32'(in_glyph_row));
    assign rd_addr = ADDR_W'(32'(code_reg) * MAX_FONT_ROWS + 32'(cmd.row));

    // Restoring division step
    assign div_part = {rem_reg, quo_reg[CELL_W-1]};
    assign div_diff = div_part - {1'b0, cpl_eff};
    assign div_take = div_part >= {1'b0, cpl_eff};

    // Word address of the current row start
    assign word_base = deep_reg ? row_base_reg[ADDR_OUT_W:1]
                                : row_base_reg[ADDR_OUT_W+1:2];

    // Write configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpl_reg  <= 8'd80;
            swp_reg  <= 11'd640;
            fh_reg   <= 6'd16;
            deep_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_CHARS_PER_LINE: cpl_reg  <= cfg_data[7:0];
                CFG_SCREEN_WIDTH:   swp_reg  <= cfg_data[10:0];
                CFG_FONT_HEIGHT:    fh_reg   <= cfg_data[5:0];
                CFG_PIXEL_DEPTH:    deep_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Glyph store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.glyph_write && row_in_range)
            glyph_mem[wr_addr] <= in_glyph_bits;
        if (cmd.row_read)
            glyph_q_reg <= glyph_mem[rd_addr];
    end

    // Capture the item, divide, then form the row base address
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            code_reg <= code_mod;
            attr_reg <= in_attribute;
            send_reg <= in_string_end;
            quo_reg  <= in_cell_index;
            rem_reg  <= 8'd0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_take ? div_diff[7:0] : div_part[7:0];
            quo_reg <= {quo_reg[CELL_W-2:0], div_take};
        end
        if (cmd.mul_line)
            line_reg <= BASE_W'(quo_reg) * BASE_W'(h_eff);
        if (cmd.mul_base)
            row_base_reg <= BASE_W'(line_reg * swp_reg)
                          + BASE_W'({rem_reg, GLYPH_SHIFT'(0)});
        else if (cmd.row_adv)
            row_base_reg <= row_base_reg + BASE_W'(swp_reg);
    end

    // Output register: hold while stalled, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_addr_reg <= word_base + ADDR_OUT_W'(cmd.word);
            out_data_reg <= tgce_expand(glyph_q_reg, attr_reg, cmd.word, deep_reg);
            out_cell_reg <= cmd.emit_last;
            out_run_reg  <= cmd.emit_last && send_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.word_address = out_addr_reg;
    assign out_ch.word_data    = out_data_reg;
    assign out_ch.cell_done    = out_cell_reg;
    assign out_ch.run_done     = out_run_reg;

    // Glyph write, item load and word emission never coincide
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.glyph_write, cmd.load, cmd.emit}))
        else $error("conflicting datapath commands");

    // 8-bit mode uses only the first two words of a row
    a_word_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && !deep_reg |-> cmd.word < 2'd2)
        else $error("word index beyond row in 8-bit mode");

    // A word is never loaded over one that waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ch.ready))
        else $error("output word overwritten");

endmodule

### rtl/tgce_controller.sv
// ----------------------------------------------------------------------------
// tgce_controller
// Sequences one item: glyph write, or divide, address setup and row/word
// emission for a draw.
// ----------------------------------------------------------------------------
module tgce_controller
    import tgce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_opcode,
    output logic      in_ready,
    input  tgce_sts_t sts,
    output tgce_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MULL = 3'd2;
    localparam logic [2:0] S_MULB = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    logic accept;
    logic last_word;
    logic last_row;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign last_word = sts.deep ? (word_reg == 2'd3) : (word_reg == 2'd1);
    assign last_row  = (ROWS_W'(row_reg) + ROWS_W'(1)) == sts.rows;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        word_next    = word_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        cmd.row      = row_reg;
        cmd.word     = word_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_opcode == OP_GLYPH_WRITE)
                    cmd.glyph_write = 1'b1;
                else if (accept && in_opcode == OP_DRAW && sts.rows != '0)
                begin
                    cmd.load     = 1'b1;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = S_MULL;
            end
            S_MULL:
            begin
                cmd.mul_line = 1'b1;
                state_next   = S_MULB;
            end
            S_MULB:
            begin
                cmd.mul_base = 1'b1;
                row_next     = '0;
                state_next   = S_READ;
            end
            S_READ:
            begin
                cmd.row_read = 1'b1;
                word_next    = '0;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = last_word && last_row;
                    if (last_word)
                    begin
                        cmd.row_adv = 1'b1;
                        if (last_row)
                            state_next = S_IDLE;
                        else
                        begin
                            row_next   = row_reg + 1'b1;
                            state_next = S_READ;
                        end
                    end
                    else
                        word_next = word_reg + 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Advance state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            row_reg     <= '0;
            word_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            word_reg    <= word_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // The divider runs its full count before the address multiply
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)
        |=> state_reg == S_MULL)
        else $error("divider left early or late");

    // The last word of a cell returns the controller to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_last |=> state_reg == S_IDLE)
        else $error("cell end without return to idle");

    // A word is emitted only when the output slot can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.slot_free && state_reg == S_EMIT)
        else $error("emit without free output slot");

endmodule

### rtl/text_glyph_color_expander.sv
// ----------------------------------------------------------------------------
// text_glyph_color_expander
// Draws text cells into a linear 32-bit framebuffer from a loaded glyph store.
//
//   channel  | dir | transfer when  | payload
//   ---------+-----+----------------+----------------------------------------
//   in_ch    | in  | valid & ready  | opcode, char_code, attribute,
//            |     |                | cell_index, glyph_row, glyph_bits,
//            |     |                | string_end
//   out_ch   | out | valid & ready  | word_address, word_data, cell_done,
//            |     |                | run_done
//   cfg      | in  | cfg_write      | cfg_index, cfg_data
//
// A glyph write is stored as it is accepted. A draw runs bit-serial division
// of the cell index, the line and base address multiplies, then per glyph
// row a glyph store read plus one word per cycle (2 or 4 per row) while the
// output is not stalled. Output stalls hold the sequencer in word emission;
// the last word waits in the output register while the next item is taken.
// Reset clears control state and loads the register defaults; glyph store
// contents are undefined.
// ----------------------------------------------------------------------------
module text_glyph_color_expander
    import tgce_pkg::*;
#(
    parameter int GLYPH_COUNT   = 256,
    parameter int MAX_FONT_ROWS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    tgce_in_if.sink                in_ch,
    tgce_out_if.source             out_ch,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    tgce_cmd_t cmd;
    tgce_sts_t sts;

    // Sequencer
    tgce_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Storage and arithmetic
    tgce_datapath #(
        .GLYPH_COUNT   (GLYPH_COUNT),
        .MAX_FONT_ROWS (MAX_FONT_ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .sts           (sts),
        .in_char_code  (in_ch.char_code),
        .in_attribute  (in_ch.attribute),
        .in_cell_index (in_ch.cell_index),
        .in_glyph_row  (in_ch.glyph_row),
        .in_glyph_bits (in_ch.glyph_bits),
        .in_string_end (in_ch.string_end),
        .out_ch        (out_ch)
    );

endmodule
